FILE: rtl/core/ifr_pkg.sv
`default_nettype none

package ifr_pkg;

  // Field widths fixed by the request and result formats
  localparam int CMD_W      = 2;
  localparam int CPU_W      = 3;
  localparam int MASK_W     = 8;
  localparam int IDX_W      = 4;
  localparam int TIME_W     = 64;
  localparam int FREQ_IDX_W = 4;
  localparam int IDLE_IDX_W = 2;

  // Configuration registers
  localparam int CFG_FREQ_W = 5;
  localparam int CFG_IDLE_W = 3;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_ADDR_W = 1;

  localparam logic [CFG_ADDR_W-1:0] CFG_FREQ_COUNT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDLE_COUNT = 1'b1;

  localparam logic [CFG_FREQ_W-1:0] FREQ_COUNT_RST = 5'd16;
  localparam logic [CFG_IDLE_W-1:0] IDLE_COUNT_RST = 3'd2;

  // Default sizes
  localparam int NUM_CPUS_DEF    = 8;
  localparam int FREQ_STATES_DEF = 16;
  localparam int IDLE_STATES_DEF = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_IDLE   = 2'd0,
    CMD_FREQ   = 2'd1,
    CMD_TOTALS = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_RESP  = 2'd0,
    OUT_TOTAL = 2'd1,
    OUT_CELL  = 2'd2
  } out_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     load_item;
    logic     rd_query;
    logic     settle_wr;
    logic     clr_wr;
    logic     acc_add;
    logic     acc_clr;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic err;
    cmd_t cmd;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/ifr_if.sv
`default_nettype none

// Request channel
interface ifr_in_if;
  logic                        valid;
  logic                        ready;
  logic [ifr_pkg::CMD_W-1:0]   command;
  logic [ifr_pkg::CPU_W-1:0]   cpu;
  logic [ifr_pkg::MASK_W-1:0]  cpu_mask;
  logic [ifr_pkg::IDX_W-1:0]   new_index;
  logic [ifr_pkg::TIME_W-1:0]  now_us;

  modport source (output valid, command, cpu, cpu_mask, new_index, now_us, input ready);
  modport sink   (input valid, command, cpu, cpu_mask, new_index, now_us, output ready);
endinterface

// Result channel
interface ifr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           status;
  logic [ifr_pkg::FREQ_IDX_W-1:0] freq_slot;
  logic [ifr_pkg::IDLE_IDX_W-1:0] idle_index;
  logic [ifr_pkg::TIME_W-1:0]     total_us;
  logic                           last;

  modport source (output valid, status, freq_slot, idle_index, total_us, last, input ready);
  modport sink   (input valid, status, freq_slot, idle_index, total_us, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ifr_ctrl.sv
`default_nettype none

module ifr_ctrl #(
  parameter int NUM_CPUS = ifr_pkg::NUM_CPUS_DEF,
  parameter int CW       = 3,
  parameter int IW       = 2,
  parameter int FW       = 4,
  parameter int AW       = CW + IW + FW
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire ifr_pkg::dp_stat_t   stat,
  input  wire [NUM_CPUS-1:0]       cpu_mask,
  input  wire [CW-1:0]             cpu_sel,
  input  wire [IW-1:0]             ni_m1,
  input  wire [FW-1:0]             nf_m1,
  output ifr_pkg::ctrl_cmd_t       cmd,
  output logic [CW-1:0]            cpu_cnt,
  output logic [IW-1:0]            idle_cnt,
  output logic [FW-1:0]            freq_cnt,
  output logic [AW-1:0]            clr_addr
);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_CHECK  = 9'b000000100,
    S_SCAN   = 9'b000001000,
    S_SET_RD = 9'b000010000,
    S_SET_WR = 9'b000100000,
    S_Q_RD   = 9'b001000000,
    S_Q_DATA = 9'b010000000,
    S_RESP   = 9'b100000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cpu_r, cpu_nxt;
  logic [IW-1:0]   j_r, j_nxt;
  logic [FW-1:0]   f_r, f_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic            cpu_last, j_last, f_last, is_query;

  assign cpu_last = (cpu_r == CW'(NUM_CPUS - 1));
  assign j_last   = (j_r == ni_m1);
  assign f_last   = (f_r == nf_m1);
  assign is_query = (stat.cmd == ifr_pkg::CMD_TOTALS) || (stat.cmd == ifr_pkg::CMD_DUMP);

  assign cpu_cnt  = cpu_r;
  assign idle_cnt = j_r;
  assign freq_cnt = f_r;
  assign clr_addr = clr_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cpu_nxt   = cpu_r;
    j_nxt     = j_r;
    f_nxt     = f_r;
    clr_nxt   = clr_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.out_sel = ifr_pkg::OUT_RESP;

    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        clr_nxt    = clr_r + AW'(1);
        if (&clr_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.err) begin
          state_nxt = S_RESP;
        end else if (stat.cmd == ifr_pkg::CMD_FREQ) begin
          cpu_nxt   = '0;
          state_nxt = S_SCAN;
        end else begin
          cpu_nxt   = cpu_sel;
          state_nxt = S_SET_RD;
        end
      end
      S_SCAN: begin
        // skip CPUs outside the mask
        if (cpu_mask[cpu_r]) state_nxt = S_SET_RD;
        else if (cpu_last)   state_nxt = S_RESP;
        else                 cpu_nxt   = cpu_r + CW'(1);
      end
      S_SET_RD: begin
        state_nxt = S_SET_WR;
      end
      S_SET_WR: begin
        cmd.settle_wr = 1'b1;
        if (is_query) begin
          cmd.acc_clr = 1'b1;
          j_nxt       = '0;
          f_nxt       = '0;
          state_nxt   = S_Q_RD;
        end else if (stat.cmd == ifr_pkg::CMD_FREQ && !cpu_last) begin
          cpu_nxt   = cpu_r + CW'(1);
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_Q_RD: begin
        cmd.rd_query = 1'b1;
        state_nxt    = S_Q_DATA;
      end
      S_Q_DATA: begin
        cmd.rd_query = 1'b1;
        if (stat.cmd == ifr_pkg::CMD_TOTALS) begin
          if (!j_last) begin
            cmd.acc_add = 1'b1;
            j_nxt       = j_r + IW'(1);
            state_nxt   = S_Q_RD;
          end else if (stat.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = ifr_pkg::OUT_TOTAL;
            cmd.out_last = f_last;
            cmd.acc_clr  = 1'b1;
            j_nxt        = '0;
            f_nxt        = f_r + FW'(1);
            state_nxt    = f_last ? S_IDLE : S_Q_RD;
          end
        end else if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = ifr_pkg::OUT_CELL;
          cmd.out_last = f_last && j_last;
          if (j_last) begin
            j_nxt     = '0;
            f_nxt     = f_r + FW'(1);
            state_nxt = f_last ? S_IDLE : S_Q_RD;
          end else begin
            j_nxt     = j_r + IW'(1);
            state_nxt = S_Q_RD;
          end
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = ifr_pkg::OUT_RESP;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cpu_r   <= '0;
      j_r     <= '0;
      f_r     <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cpu_r   <= cpu_nxt;
      j_r     <= j_nxt;
      f_r     <= f_nxt;
      clr_r   <= clr_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ifr_dp.sv
`default_nettype none

module ifr_dp #(
  parameter int NUM_CPUS    = ifr_pkg::NUM_CPUS_DEF,
  parameter int FREQ_STATES = ifr_pkg::FREQ_STATES_DEF,
  parameter int IDLE_STATES = ifr_pkg::IDLE_STATES_DEF,
  parameter int CW          = 3,
  parameter int IW          = 2,
  parameter int FW          = 4,
  parameter int AW          = CW + IW + FW
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // configuration
  input  wire                                 cfg_we,
  input  wire [ifr_pkg::CFG_ADDR_W-1:0]       cfg_index,
  input  wire [ifr_pkg::CFG_DATA_W-1:0]       cfg_data,
  // request payload
  input  wire [ifr_pkg::CMD_W-1:0]            in_command,
  input  wire [ifr_pkg::CPU_W-1:0]            in_cpu,
  input  wire [ifr_pkg::MASK_W-1:0]           in_cpu_mask,
  input  wire [ifr_pkg::IDX_W-1:0]            in_new_index,
  input  wire [ifr_pkg::TIME_W-1:0]           in_now_us,
  // result
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic                                out_status,
  output logic [ifr_pkg::FREQ_IDX_W-1:0]      out_freq_slot,
  output logic [ifr_pkg::IDLE_IDX_W-1:0]      out_idle_index,
  output logic [ifr_pkg::TIME_W-1:0]          out_total_us,
  output logic                                out_last,
  // controller
  input  wire ifr_pkg::ctrl_cmd_t             cmd,
  output ifr_pkg::dp_stat_t                   stat,
  input  wire [CW-1:0]                        cpu_cnt,
  input  wire [IW-1:0]                        idle_cnt,
  input  wire [FW-1:0]                        freq_cnt,
  input  wire [AW-1:0]                        clr_addr,
  output logic [NUM_CPUS-1:0]                 cpu_mask,
  output logic [CW-1:0]                       cpu_sel,
  output logic [IW-1:0]                       ni_m1,
  output logic [FW-1:0]                       nf_m1
);

  localparam int DEPTH = 1 << AW;

  // Configuration registers
  logic [ifr_pkg::CFG_FREQ_W-1:0] freq_count_r;
  logic [ifr_pkg::CFG_IDLE_W-1:0] idle_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_count_r <= ifr_pkg::FREQ_COUNT_RST;
      idle_count_r <= ifr_pkg::IDLE_COUNT_RST;
    end else if (cfg_we) begin
      if (cfg_index == ifr_pkg::CFG_FREQ_COUNT) freq_count_r <= cfg_data;
      if (cfg_index == ifr_pkg::CFG_IDLE_COUNT) idle_count_r <= cfg_data[ifr_pkg::CFG_IDLE_W-1:0];
    end
  end

  // Effective counts, clamped to the built sizes
  logic [ifr_pkg::CFG_FREQ_W-1:0] nf;
  logic [ifr_pkg::CFG_IDLE_W-1:0] ni;

  always_comb begin
    if (freq_count_r == '0)                                    nf = ifr_pkg::CFG_FREQ_W'(1);
    else if (freq_count_r > ifr_pkg::CFG_FREQ_W'(FREQ_STATES)) nf = ifr_pkg::CFG_FREQ_W'(FREQ_STATES);
    else                                                       nf = freq_count_r;
    if (idle_count_r == '0)                                    ni = ifr_pkg::CFG_IDLE_W'(1);
    else if (idle_count_r > ifr_pkg::CFG_IDLE_W'(IDLE_STATES)) ni = ifr_pkg::CFG_IDLE_W'(IDLE_STATES);
    else                                                       ni = idle_count_r;
  end

  assign nf_m1 = FW'(nf - ifr_pkg::CFG_FREQ_W'(1));
  assign ni_m1 = IW'(ni - ifr_pkg::CFG_IDLE_W'(1));

  // Request registers
  ifr_pkg::cmd_t                item_cmd_r;
  logic [ifr_pkg::CPU_W-1:0]    item_cpu_r;
  logic [ifr_pkg::MASK_W-1:0]   item_mask_r;
  logic [ifr_pkg::IDX_W-1:0]    item_idx_r;
  logic [ifr_pkg::TIME_W-1:0]   item_now_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_cmd_r  <= ifr_pkg::cmd_t'(in_command);
      item_cpu_r  <= in_cpu;
      item_mask_r <= in_cpu_mask;
      item_idx_r  <= in_new_index;
      item_now_r  <= in_now_us;
    end
  end

  // Request checks
  logic cpu_bad, idle_bad, freq_bad, mask_empty, err;

  assign cpu_mask   = item_mask_r[NUM_CPUS-1:0];
  assign cpu_sel    = item_cpu_r[CW-1:0];
  assign cpu_bad    = {1'b0, item_cpu_r} >= (ifr_pkg::CPU_W + 1)'(NUM_CPUS);
  assign idle_bad   = {1'b0, item_idx_r} >= {2'b00, ni};
  assign freq_bad   = {1'b0, item_idx_r} >= nf;
  assign mask_empty = ~|cpu_mask;

  always_comb begin
    case (item_cmd_r)
      ifr_pkg::CMD_IDLE: err = cpu_bad || idle_bad;
      ifr_pkg::CMD_FREQ: err = mask_empty || freq_bad;
      default:           err = cpu_bad;
    endcase
  end

  // Per-CPU state
  logic [ifr_pkg::TIME_W-1:0] stamp_r    [NUM_CPUS];
  logic [IW-1:0]              cur_idle_r [NUM_CPUS];
  logic [FW-1:0]              cur_freq_r [NUM_CPUS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CPUS; c++) begin
        stamp_r[c]    <= '0;
        cur_idle_r[c] <= '0;
        cur_freq_r[c] <= '0;
      end
    end else if (cmd.settle_wr) begin
      stamp_r[cpu_cnt] <= item_now_r;
      if (item_cmd_r == ifr_pkg::CMD_IDLE) cur_idle_r[cpu_cnt] <= item_idx_r[IW-1:0];
      if (item_cmd_r == ifr_pkg::CMD_FREQ) cur_freq_r[cpu_cnt] <= item_idx_r[FW-1:0];
    end
  end

  // Residency store: one write and one registered read per cycle
  logic [ifr_pkg::TIME_W-1:0] store [DEPTH];
  logic [ifr_pkg::TIME_W-1:0] rdata_r;
  logic [ifr_pkg::TIME_W-1:0] delta_r;
  logic [AW-1:0]              settle_addr, query_addr, rd_addr;

  assign settle_addr = {cpu_cnt, cur_idle_r[cpu_cnt], cur_freq_r[cpu_cnt]};
  assign query_addr  = {cpu_cnt, idle_cnt, freq_cnt};
  assign rd_addr     = cmd.rd_query ? query_addr : settle_addr;

  always_ff @(posedge clk) begin
    if (cmd.clr_wr)         store[clr_addr]    <= '0;
    else if (cmd.settle_wr) store[settle_addr] <= rdata_r + delta_r;
    rdata_r <= store[rd_addr];
  end

  // Elapsed time since the CPU's last update
  always_ff @(posedge clk) begin
    delta_r <= item_now_r - stamp_r[cpu_cnt];
  end

  // Totals accumulator
  logic [ifr_pkg::TIME_W-1:0] acc_r;
  logic [ifr_pkg::TIME_W-1:0] acc_sum;

  assign acc_sum = acc_r + rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.acc_clr)      acc_r <= '0;
    else if (cmd.acc_add) acc_r <= acc_sum;
  end

  // Output register
  logic                              out_valid_r;
  logic                              out_status_r;
  logic [ifr_pkg::FREQ_IDX_W-1:0]    out_freq_r;
  logic [ifr_pkg::IDLE_IDX_W-1:0]    out_idle_r;
  logic [ifr_pkg::TIME_W-1:0]        out_total_r;
  logic                              out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n)            out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ready)    out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_last_r <= cmd.out_last;
      case (cmd.out_sel)
        ifr_pkg::OUT_TOTAL: begin
          out_status_r <= 1'b0;
          out_freq_r   <= ifr_pkg::FREQ_IDX_W'(freq_cnt);
          out_idle_r   <= '0;
          out_total_r  <= acc_sum;
        end
        ifr_pkg::OUT_CELL: begin
          out_status_r <= 1'b0;
          out_freq_r   <= ifr_pkg::FREQ_IDX_W'(freq_cnt);
          out_idle_r   <= ifr_pkg::IDLE_IDX_W'(idle_cnt);
          out_total_r  <= rdata_r;
        end
        default: begin
          out_status_r <= err;
          out_freq_r   <= '0;
          out_idle_r   <= '0;
          out_total_r  <= '0;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_freq_slot  = out_freq_r;
  assign out_idle_index = out_idle_r;
  assign out_total_us   = out_total_r;
  assign out_last       = out_last_r;

  // Status to the controller
  assign stat.err      = err;
  assign stat.cmd      = item_cmd_r;
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire

FILE: rtl/core/idle_freq_residency_counters.sv
// Per-CPU idle/frequency residency counters.
// in_ch carries requests: idle change (one CPU), frequency change (CPU mask),
// per-frequency totals and one CPU's table dump. out_ch returns results; last
// marks the final one of a request. cfg_we/cfg_index/cfg_data write
// freq_count (index 0) and idle_count (index 1); the user must write them
// only while no request is open, which the block itself does not enforce.
// One request is in flight at a time; in_ch.ready is high only when idle.
// After reset the residency store is zeroed by a clearing pass over all
// 2^(CPU bits + idle bits + freq bits) entries (512 at default sizes), during
// which no request is taken. Each store update is a read-modify-write:
// S_SET_RD reads the cell and S_SET_WR writes it back. An idle change does
// one update for its CPU; a frequency change scans every CPU and updates
// each one in the mask. Queries read one cell per read port access: totals
// give one result per frequency slot, summed over idle_count cells, and a
// dump one result per cell. A stalled receiver holds the output register
// and the sequencer waits on it; nothing is dropped.
`default_nettype none

module idle_freq_residency_counters #(
  parameter int NUM_CPUS    = ifr_pkg::NUM_CPUS_DEF,
  parameter int FREQ_STATES = ifr_pkg::FREQ_STATES_DEF,
  parameter int IDLE_STATES = ifr_pkg::IDLE_STATES_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  ifr_in_if.sink                          in_ch,
  ifr_out_if.source                       out_ch,
  input  wire                             cfg_we,
  input  wire [ifr_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  wire [ifr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = (NUM_CPUS    > 1) ? $clog2(NUM_CPUS)    : 1;
  localparam int IW = (IDLE_STATES > 1) ? $clog2(IDLE_STATES) : 1;
  localparam int FW = (FREQ_STATES > 1) ? $clog2(FREQ_STATES) : 1;
  localparam int AW = CW + IW + FW;

  ifr_pkg::ctrl_cmd_t  cmd;
  ifr_pkg::dp_stat_t   stat;
  logic [CW-1:0]       cpu_cnt, cpu_sel;
  logic [IW-1:0]       idle_cnt, ni_m1;
  logic [FW-1:0]       freq_cnt, nf_m1;
  logic [AW-1:0]       clr_addr;
  logic [NUM_CPUS-1:0] cpu_mask;

  ifr_ctrl #(
    .NUM_CPUS (NUM_CPUS),
    .CW       (CW),
    .IW       (IW),
    .FW       (FW),
    .AW       (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cpu_mask (cpu_mask),
    .cpu_sel  (cpu_sel),
    .ni_m1    (ni_m1),
    .nf_m1    (nf_m1),
    .cmd      (cmd),
    .cpu_cnt  (cpu_cnt),
    .idle_cnt (idle_cnt),
    .freq_cnt (freq_cnt),
    .clr_addr (clr_addr)
  );

  ifr_dp #(
    .NUM_CPUS    (NUM_CPUS),
    .FREQ_STATES (FREQ_STATES),
    .IDLE_STATES (IDLE_STATES),
    .CW          (CW),
    .IW          (IW),
    .FW          (FW),
    .AW          (AW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_command     (in_ch.command),
    .in_cpu         (in_ch.cpu),
    .in_cpu_mask    (in_ch.cpu_mask),
    .in_new_index   (in_ch.new_index),
    .in_now_us      (in_ch.now_us),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_status     (out_ch.status),
    .out_freq_slot  (out_ch.freq_slot),
    .out_idle_index (out_ch.idle_index),
    .out_total_us   (out_ch.total_us),
    .out_last       (out_ch.last),
    .cmd            (cmd),
    .stat           (stat),
    .cpu_cnt        (cpu_cnt),
    .idle_cnt       (idle_cnt),
    .freq_cnt       (freq_cnt),
    .clr_addr       (clr_addr),
    .cpu_mask       (cpu_mask),
    .cpu_sel        (cpu_sel),
    .ni_m1          (ni_m1),
    .nf_m1          (nf_m1)
  );

endmodule

`default_nettype wire

FILE: rtl/core/ifr_checker.sv
`default_nettype none

module ifr_checker (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 in_valid,
  input wire                                 in_ready,
  input wire                                 out_valid,
  input wire                                 out_ready,
  input wire                                 out_status,
  input wire [ifr_pkg::FREQ_IDX_W-1:0]       out_freq_slot,
  input wire [ifr_pkg::TIME_W-1:0]           out_total_us,
  input wire                                 out_last
);

  // A pending result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // One request at a time: no new request right after one is taken
  a_one_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is open");

  // A request cannot start while earlier results of a query are still coming
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("request taken during a multi-result reply");

  // A rejected request gives a single zeroed result
  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last && (out_total_us == '0) && (out_freq_slot == '0))
    else $error("malformed reject result");

  // Output register is empty out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind idle_freq_residency_counters ifr_checker u_ifr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_freq_slot  (out_ch.freq_slot),
  .out_total_us   (out_ch.total_us),
  .out_last       (out_ch.last)
);

`default_nettype wire

FILE: dv/residency_checker.sv
`default_nettype none

module residency_checker (
  input  wire                            clk,
  input  wire                            rst_n,
  ifr_in_if                              in_ch,
  ifr_out_if                             out_ch,
  input  wire                            cfg_we,
  input  wire [ifr_pkg::CFG_ADDR_W-1:0]  cfg_index,
  input  wire [ifr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                             mismatches,
  output int                             outstanding
);
  import ifr_pkg::*;

  localparam int NCPU  = NUM_CPUS_DEF;
  localparam int NFREQ = FREQ_STATES_DEF;
  localparam int NIDLE = IDLE_STATES_DEF;

  typedef struct packed {
    logic                  status;
    logic [FREQ_IDX_W-1:0] freq_slot;
    logic [IDLE_IDX_W-1:0] idle_index;
    logic [TIME_W-1:0]     total_us;
    logic                  last;
  } report_t;

  // Results still owed by the block, oldest first
  report_t awaited[$];

  // Shadow of the block's accounting state
  logic [TIME_W-1:0]     cell_us [NCPU][NIDLE][NFREQ];
  logic [TIME_W-1:0]     stamp_us [NCPU];
  logic [IDLE_IDX_W-1:0] idle_now [NCPU];
  logic [FREQ_IDX_W-1:0] freq_now [NCPU];
  logic [CFG_FREQ_W-1:0] freq_count;
  logic [CFG_IDLE_W-1:0] idle_count;

  initial mismatches = 0;

  // Out-of-range register values clamp to the nearest legal count
  function automatic int freq_span();
    if (freq_count == '0) return 1;
    if (freq_count > NFREQ) return NFREQ;
    return int'(freq_count);
  endfunction

  function automatic int idle_span();
    if (idle_count == '0) return 1;
    if (idle_count > NIDLE) return NIDLE;
    return int'(idle_count);
  endfunction

  // Close the open interval of one CPU into its current cell
  task automatic accrue(input int c, input logic [TIME_W-1:0] t);
    cell_us[c][idle_now[c]][freq_now[c]] += t - stamp_us[c];
    stamp_us[c] = t;
  endtask

  task automatic owe(input logic st, input int fi, input int ii,
                     input logic [TIME_W-1:0] tot, input logic lst);
    report_t r;
    r.status     = st;
    r.freq_slot  = fi[FREQ_IDX_W-1:0];
    r.idle_index = ii[IDLE_IDX_W-1:0];
    r.total_us   = tot;
    r.last       = lst;
    awaited.push_back(r);
  endtask

  task automatic note_fault(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $time, msg);
  endtask

  // Update the shadow state for one accepted request and queue its results
  task automatic apply_request();
    cmd_t              op;
    int                c;
    int                nf;
    int                ni;
    logic [MASK_W-1:0] m;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] sum;
    op  = cmd_t'(in_ch.command);
    c   = int'(in_ch.cpu);
    m   = in_ch.cpu_mask & MASK_W'((1 << NCPU) - 1);
    idx = in_ch.new_index;
    t   = in_ch.now_us;
    nf  = freq_span();
    ni  = idle_span();
    case (op)
      CMD_IDLE: begin
        if (c >= NCPU || idx >= ni) begin
          owe(1'b1, 0, 0, '0, 1'b1);
        end else begin
          accrue(c, t);
          idle_now[c] = idx[IDLE_IDX_W-1:0];
          owe(1'b0, 0, 0, '0, 1'b1);
        end
      end
      CMD_FREQ: begin
        if (m == '0 || idx >= nf) begin
          owe(1'b1, 0, 0, '0, 1'b1);
        end else begin
          for (int i = 0; i < NCPU; i++) begin
            if (m[i]) begin
              accrue(i, t);
              freq_now[i] = idx[FREQ_IDX_W-1:0];
            end
          end
          owe(1'b0, 0, 0, '0, 1'b1);
        end
      end
      default: begin
        if (c >= NCPU) begin
          owe(1'b1, 0, 0, '0, 1'b1);
        end else begin
          accrue(c, t);
          for (int f = 0; f < nf; f++) begin
            if (op == CMD_TOTALS) begin
              sum = '0;
              for (int j = 0; j < ni; j++) sum += cell_us[c][j][f];
              owe(1'b0, f, 0, sum, f == nf - 1);
            end else begin
              for (int j = 0; j < ni; j++)
                owe(1'b0, f, j, cell_us[c][j][f], (f == nf - 1) && (j == ni - 1));
            end
          end
        end
      end
    endcase
  endtask

  // Compare one accepted result with the oldest one owed
  task automatic check_report();
    report_t want;
    if (awaited.size() == 0) begin
      note_fault($sformatf("unexpected result: st=%0d f=%0d i=%0d total=%0h last=%0d",
                           out_ch.status, out_ch.freq_slot, out_ch.idle_index,
                           out_ch.total_us, out_ch.last));
    end else begin
      want = awaited.pop_front();
      if (out_ch.status !== want.status || out_ch.freq_slot !== want.freq_slot ||
          out_ch.idle_index !== want.idle_index || out_ch.total_us !== want.total_us ||
          out_ch.last !== want.last) begin
        note_fault($sformatf({"result mismatch: expected st=%0d f=%0d i=%0d total=%0h last=%0d,",
                              " got st=%0d f=%0d i=%0d total=%0h last=%0d"},
                             want.status, want.freq_slot, want.idle_index, want.total_us,
                             want.last, out_ch.status, out_ch.freq_slot, out_ch.idle_index,
                             out_ch.total_us, out_ch.last));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCPU; c++) begin
        stamp_us[c] = '0;
        idle_now[c] = '0;
        freq_now[c] = '0;
        for (int j = 0; j < NIDLE; j++)
          for (int f = 0; f < NFREQ; f++) cell_us[c][j][f] = '0;
      end
      freq_count = FREQ_COUNT_RST;
      idle_count = IDLE_COUNT_RST;
      awaited.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FREQ_COUNT: freq_count = cfg_data[CFG_FREQ_W-1:0];
          CFG_IDLE_COUNT: idle_count = cfg_data[CFG_IDLE_W-1:0];
          default: ;
        endcase
      end
      // results first: a request accepted now cannot answer at this edge
      if (out_ch.valid && out_ch.ready) check_report();
      if (in_ch.valid && in_ch.ready) apply_request();
    end
    outstanding = awaited.size();
  end

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none

module testbench;
  import ifr_pkg::*;

  localparam int RUN_LIMIT   = 400000;
  localparam int HOLD_CYCLES = 400;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    send_idle_pct;
  int                    stall_pct;
  int                    hold_seq;
  int                    mismatches;
  int                    outstanding;
  int                    cycle_count = 0;
  int                    freq_live;
  int                    idle_live;
  logic [TIME_W-1:0]     stamp_us;

  ifr_in_if  in_ch ();
  ifr_out_if out_ch ();

  idle_freq_residency_counters dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  residency_checker check_u (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever hold_seq moves
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one request and hold it until taken; called and returns at a falling edge
  task automatic send_req(input cmd_t op, input logic [CPU_W-1:0] cpu,
                          input logic [MASK_W-1:0] mask, input logic [IDX_W-1:0] idx,
                          input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= op;
    in_ch.cpu       <= cpu;
    in_ch.cpu_mask  <= mask;
    in_ch.new_index <= idx;
    in_ch.now_us    <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering until every owed result is back and the block takes requests again
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0 || !in_ch.ready);
  endtask

  task automatic set_counts(input int fc, input int ic);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FREQ_COUNT;
    cfg_data  <= fc[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= CFG_IDLE_COUNT;
    cfg_data  <= ic[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    freq_live = (fc == 0) ? 1 : (fc > FREQ_STATES_DEF) ? FREQ_STATES_DEF : fc;
    idle_live = (ic == 0) ? 1 : (ic > IDLE_STATES_DEF) ? IDLE_STATES_DEF : ic;
  endtask

  // Mostly forward time, sometimes backward, now and then anywhere in 64 bits
  task automatic step_time();
    int pick;
    pick = $urandom_range(99);
    if (pick < 88)      stamp_us += $urandom_range(4000, 1);
    else if (pick < 94) stamp_us -= $urandom_range(2000);
    else                stamp_us = {$urandom, $urandom};
  endtask

  task automatic rand_req();
    int                pick;
    int                span;
    cmd_t              op;
    logic [IDX_W-1:0]  idx;
    logic [MASK_W-1:0] mask;
    pick = $urandom_range(99);
    if (pick < 40)      op = CMD_IDLE;
    else if (pick < 75) op = CMD_FREQ;
    else if (pick < 90) op = CMD_TOTALS;
    else                op = CMD_DUMP;
    span = (op == CMD_IDLE) ? idle_live : freq_live;
    // mostly legal indexes so state keeps moving; the rest may hit the range check
    if ($urandom_range(99) < 85) idx = IDX_W'($urandom_range(span - 1));
    else                         idx = IDX_W'($urandom_range(15));
    if ($urandom_range(99) < 5) mask = '0;
    else                        mask = MASK_W'($urandom_range(255));
    step_time();
    send_req(op, CPU_W'($urandom_range(7)), mask, idx, stamp_us);
  endtask

  task automatic run_phase(input int fc, input int ic, input int idle_pct, input int stall,
                           input int count, input int hold_at, input int pause_at);
    set_counts(fc, ic);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    for (int k = 0; k < count; k++) begin
      if (k == hold_at) hold_seq++;
      if (k == pause_at) drain();
      rand_req();
    end
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_IDLE;
    in_ch.cpu       = '0;
    in_ch.cpu_mask  = '0;
    in_ch.new_index = '0;
    in_ch.now_us    = '0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_FREQ_COUNT;
    cfg_data        = '0;
    rst_n           = 1'b0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_seq        = 0;
    stamp_us        = '0;
    freq_live       = int'(FREQ_COUNT_RST);
    idle_live       = int'(IDLE_COUNT_RST);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset counts first, then clamped-low, then clamped-high registers
    send_req(CMD_IDLE,   3'd0, 8'h00, 4'd1,  64'd100);
    send_req(CMD_FREQ,   3'd0, 8'hFF, 4'd15, 64'd250);
    send_req(CMD_IDLE,   3'd7, 8'h00, 4'd1,  64'd400);
    // idle index at and far beyond the idle count
    send_req(CMD_IDLE,   3'd3, 8'h00, 4'd2,  64'd450);
    send_req(CMD_IDLE,   3'd3, 8'h00, 4'd15, 64'd460);
    // empty mask
    send_req(CMD_FREQ,   3'd0, 8'h00, 4'd2,  64'd470);
    send_req(CMD_FREQ,   3'd0, 8'h81, 4'd0,  64'd500);
    send_req(CMD_TOTALS, 3'd0, 8'h00, 4'd0,  64'd600);
    send_req(CMD_DUMP,   3'd7, 8'hFF, 4'd15, 64'd700);
    // time going backward, then all-ones and zero timestamps
    send_req(CMD_IDLE,   3'd0, 8'h00, 4'd0,  64'd50);
    send_req(CMD_FREQ,   3'd0, 8'h01, 4'd3,  '1);
    send_req(CMD_TOTALS, 3'd0, 8'h00, 4'd0,  64'd0);

    // zero counts act as one; CPUs left above the new counts keep accruing
    set_counts(0, 0);
    send_req(CMD_IDLE,   3'd7, 8'h00, 4'd0,  64'd800);
    send_req(CMD_IDLE,   3'd2, 8'h00, 4'd1,  64'd810);
    send_req(CMD_FREQ,   3'd0, 8'h02, 4'd1,  64'd820);
    send_req(CMD_FREQ,   3'd0, 8'h7E, 4'd0,  64'd830);
    send_req(CMD_TOTALS, 3'd0, 8'h00, 4'd0,  64'd900);
    send_req(CMD_DUMP,   3'd7, 8'h00, 4'd0,  64'd910);

    // counts above the store size act as the maximum
    set_counts(31, 7);
    send_req(CMD_IDLE,   3'd5, 8'h00, 4'd3,  64'd1000);
    send_req(CMD_FREQ,   3'd0, 8'h20, 4'd15, 64'd1100);
    send_req(CMD_DUMP,   3'd5, 8'h00, 4'd0,  64'd1200);
    send_req(CMD_TOTALS, 3'd5, 8'h00, 4'd0,  64'd1300);
    send_req(CMD_DUMP,   3'd0, 8'h00, 4'd0,  64'd1400);
    stamp_us = 64'd1400;

    // Random phases
    run_phase(16, 4, 0, 0, 30, -1, -1);
    run_phase(1, 1, 61, 0, 20, -1, -1);
    run_phase($urandom_range(16, 1), $urandom_range(4, 1), 0, 61, 30, 6, -1);
    run_phase($urandom_range(31), $urandom_range(7), 20, 20, 30, -1, -1);
    run_phase(16, 2, 0, 0, 27, 12, 20);

    drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/ifr_pkg.sv
rtl/core/ifr_if.sv
rtl/core/ifr_ctrl.sv
rtl/core/ifr_dp.sv
rtl/core/idle_freq_residency_counters.sv
rtl/core/ifr_checker.sv
dv/residency_checker.sv
dv/testbench.sv
